// File: sv/epmf_pkg.sv
// shared types, constants and helpers for the exact pattern match finder
package epmf_pkg;

    // default window depth in bytes
    localparam int MAX_PATTERN_DEF = 16;

    // pattern register geometry
    localparam int PAT_BYTES   = 16;
    localparam int PAT_IDX_W   = 4;
    localparam int POS_W       = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 5;
    localparam int RAW_LEN_W   = 5;

    // register indexes on the configuration port
    localparam logic [1:0] REG_PATTERN_LOW    = 2'd0;
    localparam logic [1:0] REG_PATTERN_HIGH   = 2'd1;
    localparam logic [1:0] REG_PATTERN_LENGTH = 2'd2;

    typedef logic [7:0] byte_t;

    // per-cycle control for the window cells
    typedef struct packed {
        logic shift;
        logic clear;
    } epmf_cell_ctrl_t;

    // pick pattern byte idx out of the two 64-bit pattern registers
    function automatic byte_t pattern_byte(input logic [63:0] lo,
                                           input logic [63:0] hi,
                                           input logic [PAT_IDX_W-1:0] idx);
        logic [127:0] both;
        both = {hi, lo};
        return both[{idx, 3'b000} +: 8];
    endfunction

endpackage

// File: sv/epmf_cell.sv
// one window cell: holds a text byte and compares the incoming byte
module epmf_cell
    import epmf_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  epmf_cell_ctrl_t ctrl,
    input  byte_t           byte_in,
    input  byte_t           exp_byte,
    input  logic            active,
    output byte_t           byte_out,
    output logic            hit
);

    byte_t byte_reg;
    byte_t byte_next;

    // compare the byte that moves into this cell on this transfer
    assign hit = !active || (byte_in == exp_byte);

    // shift from the neighbor, cleared at end of text
    always_comb begin
        byte_next = byte_reg;
        if (ctrl.clear) begin
            byte_next = '0;
        end else if (ctrl.shift) begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= '0;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

endmodule

// File: sv/epmf_out_buf.sv
// two-entry output buffer: output register plus skid register
module epmf_out_buf
    import epmf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [POS_W-1:0] push_data,
    output logic             space,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [POS_W-1:0] m_match_start
);

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [POS_W-1:0] out_data_reg;
    logic [POS_W-1:0] out_data_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    logic [POS_W-1:0] skid_data_reg;
    logic [POS_W-1:0] skid_data_next;
    logic             pop;

    assign pop   = out_valid_reg && m_ready;
    assign space = !skid_valid_reg;

    // fill and drain
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_match_start = out_data_reg;

    // skid entry only ever sits behind a full output register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without output entry");

    // a skidded result moves up when the output drains
    a_skid_moves_up: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && m_ready |=> out_valid_reg && (out_data_reg == $past(skid_data_reg)))
        else $error("skid entry lost on drain");

endmodule

// File: sv/exact_pattern_match_finder_top.sv
// top level: config registers, position counter, cell chain and result buffer
//
// Streams text bytes and reports every start position where the configured
// pattern (up to MAX_PATTERN bytes, length 0 matches everywhere) matches
// exactly, overlapping matches included, in ascending order. One byte is
// accepted per clock; a result is pushed with the byte that completes it. The
// rate is set by the row of MAX_PATTERN window cells, which all compare their
// incoming byte in the same cycle and are reduced into the result register. A
// two-entry output buffer keeps input flowing while one result waits; s_ready
// drops only while both entries are full. The byte flagged end_of_text closes
// the text: window and position clear after it. The position saturates at
// 4294967295. Registers sit at byte addresses 0 (pattern_low), 8
// (pattern_high) and 16 (pattern_length), 64 bits wide; the user must ensure
// they are written only while the block is idle; the block does not check.
module exact_pattern_match_finder_top
    import epmf_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // text input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_text_byte,
    input  logic                  s_end_of_text,
    // match results
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [POS_W-1:0]      m_match_start,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
    localparam int CLAMP_W = (LEN_W > RAW_LEN_W) ? LEN_W : RAW_LEN_W;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    logic [63:0]          pattern_low_reg;
    logic [63:0]          pattern_high_reg;
    logic [RAW_LEN_W-1:0] pattern_length_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;

    logic                 cfg_write;
    logic [1:0]           cfg_index;
    logic                 accept;
    logic                 space;
    logic [CLAMP_W-1:0]   len_raw;
    logic [LEN_W-1:0]     len_c;
    logic [POS_W-1:0]     len_m1;
    logic [MAX_PATTERN-1:0] hits;
    logic                 result_hit;
    logic [POS_W-1:0]     result_start;
    epmf_cell_ctrl_t      cell_ctrl;
    byte_t                chain [MAX_PATTERN];

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[CFG_ADDR_W-1:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= '0;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_PATTERN_LOW:    pattern_low_reg    <= pwdata;
                REG_PATTERN_HIGH:   pattern_high_reg   <= pwdata;
                REG_PATTERN_LENGTH: pattern_length_reg <= pwdata[RAW_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_PATTERN_LOW:    prdata = pattern_low_reg;
            REG_PATTERN_HIGH:   prdata = pattern_high_reg;
            REG_PATTERN_LENGTH: prdata = CFG_DATA_W'(pattern_length_reg);
            default:            prdata = '0;
        endcase
    end

    // effective length, clamped to the window depth
    assign len_raw = CLAMP_W'(pattern_length_reg);
    assign len_c   = (len_raw > CLAMP_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                       : LEN_W'(len_raw);
    assign len_m1  = (len_c == '0) ? '0 : (POS_W'(len_c) - POS_W'(1));

    // input handshake and cell control
    assign s_ready         = space;
    assign accept          = s_valid && s_ready;
    assign cell_ctrl.shift = accept;
    assign cell_ctrl.clear = accept && s_end_of_text;
    assign chain[0]        = s_text_byte;

    // row of window cells, cell k holds the byte k places back
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic [LEN_W-1:0] sel;
        logic             active;
        byte_t            exp_byte;

        assign active   = LEN_W'(k) < len_c;
        assign sel      = len_c - LEN_W'(k) - LEN_W'(1);
        assign exp_byte = (32'(sel) < PAT_BYTES)
                        ? pattern_byte(pattern_low_reg, pattern_high_reg, PAT_IDX_W'(sel))
                        : '0;

        if (k < MAX_PATTERN - 1) begin : g_mid
            epmf_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (cell_ctrl),
                .byte_in  (chain[k]),
                .exp_byte (exp_byte),
                .active   (active),
                .byte_out (chain[k+1]),
                .hit      (hits[k])
            );
        end else begin : g_last
            epmf_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (cell_ctrl),
                .byte_in  (chain[k]),
                .exp_byte (exp_byte),
                .active   (active),
                .byte_out (),
                .hit      (hits[k])
            );
        end
    end

    // full match lying wholly inside the current text
    assign result_hit   = (&hits) && (pos_reg >= len_m1);
    assign result_start = pos_reg - len_m1;

    // text position counter
    always_comb begin
        pos_next = pos_reg;
        if (accept) begin
            if (s_end_of_text) begin
                pos_next = '0;
            end else if (pos_reg != POS_MAX) begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    // result buffer
    epmf_out_buf u_out_buf (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (accept && result_hit),
        .push_data     (result_start),
        .space         (space),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_match_start (m_match_start)
    );

    // end of text restarts the position
    a_eot_clears_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_end_of_text |=> pos_reg == '0)
        else $error("position not cleared after end of text");

    // position advances by one per byte until saturation
    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_end_of_text && (pos_reg != POS_MAX) |=> pos_reg == $past(pos_reg) + POS_W'(1))
        else $error("position did not advance");

    // an empty pattern reports on every byte
    a_empty_pattern_hits: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (pattern_length_reg == '0) |=> m_valid)
        else $error("empty pattern produced no result");

endmodule
